@@ design/polygon_region_point_test_assert.svh @@
// Assertion helpers used by the top-level design file.
`ifndef POLYGON_REGION_POINT_TEST_ASSERT_SVH
`define POLYGON_REGION_POINT_TEST_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define PRPT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define PRPT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ design/prpt_pkg.sv @@
`default_nettype none
package prpt_pkg;

	// Coordinate width of the stored vertices and query points
	localparam int CW = 32;

	localparam int MAX_VERTICES_DEF = 256;
	localparam int MAX_RINGS_DEF    = 16;
	localparam int MAX_REGIONS_DEF  = 8;

	typedef enum logic [1:0] {
		FN_CLEAR  = 2'd0,
		FN_APPEND = 2'd1,
		FN_QUERY  = 2'd2,
		FN_NOP    = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_VTX_FULL  = 3'd1,
		ST_RING_FULL = 3'd2,
		ST_OUTER_DUP = 3'd3,
		ST_NO_RING   = 3'd4
	} status_t;

	// One edge handed to the crossing unit
	typedef struct packed {
		logic                 vld;
		logic signed [CW-1:0] xi;
		logic signed [CW-1:0] yi;
		logic signed [CW-1:0] xj;
		logic signed [CW-1:0] yj;
	} edge_t;

	// Crossing unit status back to the controller
	typedef struct packed {
		logic vld;
		logic flip;
		logic busy;
	} edge_res_t;

	// Reduce a region number below the region count
	function automatic logic [2:0] region_mod(input logic [2:0] r, input int m);
		logic [3:0] v;
		v = {1'b0, r};
		for (int i = 0; i < 8; i++) begin
			if (int'(v) >= m) begin
				v = v - 4'(m);
			end
		end
		return v[2:0];
	endfunction

endpackage
`default_nettype wire

@@ design/prpt_vstore.sv @@
`default_nettype none
module prpt_vstore #(
	parameter int DEPTH = prpt_pkg::MAX_VERTICES_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [AW-1:0]               waddr,
	input  wire logic [2*prpt_pkg::CW-1:0]   wdata,
	input  wire logic                        re,
	input  wire logic [AW-1:0]               raddr,
	output logic      [2*prpt_pkg::CW-1:0]   rdata
);
	import prpt_pkg::*;

	logic [2*CW-1:0] mem_q [DEPTH];

	// Write one vertex, read one vertex with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

@@ design/prpt_rtab.sv @@
`default_nettype none
module prpt_rtab #(
	parameter int DEPTH = prpt_pkg::MAX_RINGS_DEF,
	parameter int AW    = 1,
	parameter int W     = 8
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);
	import prpt_pkg::*;

	logic [W-1:0] mem_q [DEPTH];

	// Store ring descriptors, read one with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

@@ design/prpt_edge.sv @@
`default_nettype none
module prpt_edge (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire prpt_pkg::edge_t               edge_in,
	input  wire logic signed [prpt_pkg::CW-1:0] qx,
	input  wire logic signed [prpt_pkg::CW-1:0] qy,
	output prpt_pkg::edge_res_t                res
);
	import prpt_pkg::*;

	logic                 v_s1, v_s2, v_s3;
	logic                 span_s1, span_s2;
	logic                 dypos_s1, dypos_s2;
	logic signed [CW:0]   dxq_s1, dy_s1, dxe_s1, dyq_s1;
	logic signed [2*CW+1:0] p1_s2, p2_s2;
	logic                 flip_s3;

	// Valid bits of the three stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= edge_in.vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: differences and the straddle test; stage 2: products; stage 3: compare
	always_ff @(posedge clk) begin
		span_s1  <= (edge_in.yi > qy) != (edge_in.yj > qy);
		dxq_s1   <= (CW+1)'(qx) - (CW+1)'(edge_in.xi);
		dy_s1    <= (CW+1)'(edge_in.yj) - (CW+1)'(edge_in.yi);
		dxe_s1   <= (CW+1)'(edge_in.xj) - (CW+1)'(edge_in.xi);
		dyq_s1   <= (CW+1)'(qy) - (CW+1)'(edge_in.yi);
		dypos_s1 <= edge_in.yj > edge_in.yi;
		span_s2  <= span_s1;
		dypos_s2 <= dypos_s1;
		p1_s2    <= (2*CW+2)'(dxq_s1) * (2*CW+2)'(dy_s1);
		p2_s2    <= (2*CW+2)'(dxe_s1) * (2*CW+2)'(dyq_s1);
		flip_s3  <= span_s2 && (dypos_s2 ? (p1_s2 < p2_s2) : (p1_s2 > p2_s2));
	end

	assign res.vld  = v_s3;
	assign res.flip = flip_s3;
	assign res.busy = v_s1 | v_s2 | v_s3;
endmodule
`default_nettype wire

@@ design/polygon_region_point_test.sv @@
// Keepout polygon region store with point-in-region query.
// Input channel s_*: one item per command. tuser carries func (0 clear,
// 1 append vertex, 2 query point). Output channel m_*: exactly one result item
// per input item, in order, carrying status, inside_res and hit_region.
// An input item is taken only while the controller is idle; a finished result
// waits in the output register, and the next item is accepted meanwhile.
// Clear and append pass from the execute state straight to the done state.
// A query walks every stored ring of at least three vertices, skipping shorter
// rings: every edge goes through the single read port of the vertex memory,
// one edge per cycle into a three-stage crossing unit, and the region flags
// are scanned one per cycle at the end.
// Reset empties the region store (ring and vertex counts, outer flags) and
// drops any pending result; memory contents are not touched.
// When the receiver stalls, the result holds in the output register and the
// controller waits with the next result until the register is free.
`default_nettype none
module polygon_region_point_test #(
	parameter int MAX_VERTICES = prpt_pkg::MAX_VERTICES_DEF,
	parameter int MAX_RINGS    = prpt_pkg::MAX_RINGS_DEF,
	parameter int MAX_REGIONS  = prpt_pkg::MAX_REGIONS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// new_ring[0], region[3:1], is_hole[4], x[36:5], y[68:37], zero fill
	input  wire logic [71:0] s_tdata,
	// func[1:0]
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// status[2:0], inside_res[3], hit_region[6:4], zero fill
	output logic [7:0]       m_tdata
);
	import prpt_pkg::*;

	localparam int VAW = $clog2(MAX_VERTICES);
	localparam int VCW = $clog2(MAX_VERTICES + 1);
	localparam int RAW = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1;
	localparam int RCW = $clog2(MAX_RINGS + 1);
	localparam int GW  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int RTW = VAW + VCW + GW + 1;

	typedef enum logic [2:0] {
		S_IDLE, S_EXEC, S_RRD, S_RDAT, S_VTX, S_DRAIN, S_SCAN, S_DONE
	} state_t;

	state_t                  state_q;
	logic [1:0]              func_q;
	logic                    new_q, hole_q;
	logic [GW-1:0]           reg_q;
	logic signed [CW-1:0]    x_q, y_q;
	logic [RCW-1:0]          rings_q;
	logic [VCW-1:0]          verts_q;
	logic [MAX_REGIONS-1:0]  outer_q, oodd_q, hodd_q;
	logic [VAW-1:0]          cur_start_q;
	logic [VCW-1:0]          cur_len_q;
	logic [GW-1:0]           cur_own_q;
	logic                    cur_hole_q;
	logic [RCW-1:0]          ring_q;
	logic [VAW-1:0]          rs_q;
	logic [VCW-1:0]          rn_q, k_q;
	logic [GW-1:0]           ro_q, scan_q;
	logic                    rh_q, odd_q;
	logic                    rd_pend_q, rd_first_q;
	logic signed [CW-1:0]    px_q, py_q;
	logic [2:0]              st_q, hit_q;
	logic                    ins_q;

	logic                    app_ok;
	logic [2:0]              app_st;
	logic [RAW-1:0]          rt_waddr;
	logic [RTW-1:0]          rt_wdata, rt_rdata;
	logic                    rt_re;
	logic                    vs_re;
	logic [VAW-1:0]          vs_raddr;
	logic [2*CW-1:0]         vs_rdata;
	logic [VCW-1:0]          last_idx;
	edge_t                   edge_in;
	edge_res_t               edge_res;
	logic signed [CW-1:0]    rx, ry;

	// Check an append and build its ring descriptor
	always_comb begin
		app_st = ST_OK;
		if (!new_q && rings_q == '0) begin
			app_st = ST_NO_RING;
		end else if (int'(verts_q) >= MAX_VERTICES) begin
			app_st = ST_VTX_FULL;
		end else if (new_q && int'(rings_q) >= MAX_RINGS) begin
			app_st = ST_RING_FULL;
		end else if (new_q && !hole_q && outer_q[reg_q]) begin
			app_st = ST_OUTER_DUP;
		end
		app_ok   = (state_q == S_EXEC) && (func_q == FN_APPEND) && (app_st == ST_OK);
		rt_waddr = new_q ? rings_q[RAW-1:0] : RAW'(rings_q - RCW'(1));
		rt_wdata = new_q ? {verts_q[VAW-1:0], VCW'(1), reg_q, hole_q}
		                 : {cur_start_q, VCW'(cur_len_q + VCW'(1)), reg_q, hole_q};
		if (!new_q) begin
			rt_wdata[GW:0] = {cur_own_q, cur_hole_q};
		end
	end

	// Ring walk: the closing vertex first, then the ring in order
	always_comb begin
		last_idx = VCW'(rs_q) + rn_q - VCW'(1);
		rt_re    = (state_q == S_RRD);
		vs_re    = (state_q == S_VTX);
		vs_raddr = (k_q == '0) ? last_idx[VAW-1:0] : VAW'(VCW'(rs_q) + k_q - VCW'(1));
		rx       = vs_rdata[CW-1:0];
		ry       = vs_rdata[2*CW-1:CW];
		edge_in.vld = rd_pend_q && !rd_first_q;
		edge_in.xi  = rx;
		edge_in.yi  = ry;
		edge_in.xj  = px_q;
		edge_in.yj  = py_q;
	end

	prpt_vstore #(.DEPTH(MAX_VERTICES), .AW(VAW)) u_vstore (
		.clk   (clk),
		.we    (app_ok),
		.waddr (verts_q[VAW-1:0]),
		.wdata ({y_q, x_q}),
		.re    (vs_re),
		.raddr (vs_raddr),
		.rdata (vs_rdata)
	);

	prpt_rtab #(.DEPTH(MAX_RINGS), .AW(RAW), .W(RTW)) u_rtab (
		.clk   (clk),
		.we    (app_ok),
		.waddr (rt_waddr),
		.wdata (rt_wdata),
		.re    (rt_re),
		.raddr (ring_q[RAW-1:0]),
		.rdata (rt_rdata)
	);

	prpt_edge u_edge (
		.clk     (clk),
		.arst_n  (arst_n),
		.edge_in (edge_in),
		.qx      (x_q),
		.qy      (y_q),
		.res     (edge_res)
	);

	assign s_tready = (state_q == S_IDLE);

	// Controller, region store counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rings_q   <= '0;
			verts_q   <= '0;
			outer_q   <= '0;
			rd_pend_q <= 1'b0;
			m_tvalid  <= 1'b0;
		end else begin
			// load a finished result, drop a taken one
			if (state_q == S_DONE && (!m_tvalid || m_tready)) begin
				m_tvalid <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			// track the vertex read in flight
			rd_pend_q  <= vs_re;
			rd_first_q <= (k_q == '0);
			if (rd_pend_q) begin
				px_q <= rx;
				py_q <= ry;
			end
			if (edge_res.vld && edge_res.flip) begin
				odd_q <= !odd_q;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						func_q  <= s_tuser;
						new_q   <= s_tdata[0];
						reg_q   <= GW'(region_mod(s_tdata[3:1], MAX_REGIONS));
						hole_q  <= s_tdata[4];
						x_q     <= s_tdata[36:5];
						y_q     <= s_tdata[68:37];
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					st_q    <= (func_q == FN_APPEND) ? app_st : ST_OK;
					ins_q   <= 1'b0;
					hit_q   <= '0;
					if (func_q == FN_QUERY) begin
						state_q <= (rings_q == '0) ? S_SCAN : S_RRD;
					end else begin
						state_q <= S_DONE;
					end
					unique case (func_t'(func_q))
						FN_CLEAR: begin
							rings_q <= '0;
							verts_q <= '0;
							outer_q <= '0;
						end
						FN_APPEND: begin
							if (app_st == ST_OK) begin
								verts_q <= verts_q + VCW'(1);
								if (new_q) begin
									rings_q     <= rings_q + RCW'(1);
									cur_start_q <= verts_q[VAW-1:0];
									cur_len_q   <= VCW'(1);
									cur_own_q   <= reg_q;
									cur_hole_q  <= hole_q;
									if (!hole_q) begin
										outer_q[reg_q] <= 1'b1;
									end
								end else begin
									cur_len_q <= cur_len_q + VCW'(1);
								end
							end
						end
						FN_QUERY: begin
							oodd_q  <= '0;
							hodd_q  <= '0;
							ring_q  <= '0;
							scan_q  <= '0;
						end
						default: begin
						end
					endcase
				end
				S_RRD: begin
					state_q <= S_RDAT;
				end
				S_RDAT: begin
					rs_q  <= rt_rdata[RTW-1 -: VAW];
					rn_q  <= rt_rdata[VCW+GW : GW+1];
					ro_q  <= rt_rdata[GW:1];
					rh_q  <= rt_rdata[0];
					odd_q <= 1'b0;
					k_q   <= '0;
					if (int'(rt_rdata[VCW+GW : GW+1]) >= 3) begin
						state_q <= S_VTX;
					end else begin
						ring_q  <= ring_q + RCW'(1);
						state_q <= (ring_q + RCW'(1) == rings_q) ? S_SCAN : S_RRD;
					end
				end
				S_VTX: begin
					k_q <= k_q + VCW'(1);
					if (k_q == rn_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!rd_pend_q && !edge_res.busy) begin
						if (odd_q) begin
							if (rh_q) begin
								hodd_q[ro_q] <= 1'b1;
							end else begin
								oodd_q[ro_q] <= 1'b1;
							end
						end
						ring_q  <= ring_q + RCW'(1);
						state_q <= (ring_q + RCW'(1) == rings_q) ? S_SCAN : S_RRD;
					end
				end
				S_SCAN: begin
					if (oodd_q[scan_q] && !hodd_q[scan_q]) begin
						ins_q   <= 1'b1;
						hit_q   <= 3'(scan_q);
						state_q <= S_DONE;
					end else if (scan_q == GW'(MAX_REGIONS - 1)) begin
						state_q <= S_DONE;
					end else begin
						scan_q <= scan_q + GW'(1);
					end
				end
				S_DONE: begin
					if (!m_tvalid || m_tready) begin
						m_tdata  <= {1'b0, hit_q, ins_q, st_q};
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`include "polygon_region_point_test_assert.svh"

	`PRPT_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)
	`PRPT_ASSERT_NOW(a_vert_bound, 1'b1, int'(verts_q) <= MAX_VERTICES)
	`PRPT_ASSERT_NOW(a_ring_bound, 1'b1, int'(rings_q) <= MAX_RINGS)
	`PRPT_ASSERT_NOW(a_err_not_inside, m_tvalid && m_tdata[2:0] != ST_OK, !m_tdata[3])
	`PRPT_ASSERT_NOW(a_walk_quiet, state_q == S_IDLE, !edge_res.busy && !rd_pend_q)
endmodule
`default_nettype wire
